[design/sca_pkg.sv]
package sca_pkg;

  localparam int NUM_HEAPS_DEF   = 8;
  localparam int HEAP_BYTES_DEF  = 16384;
  localparam int NUM_CLASSES_DEF = 256;

  localparam int ADDR_W   = 17;
  localparam int SIZE_W   = 24;
  localparam int THR_W    = 15;
  localparam int STATUS_W = 2;
  localparam int CLASS_W  = 8;
  localparam int HEAP_W   = 3;

  localparam logic [THR_W-1:0] THR_RESET = 15'd4096;
  localparam logic [7:0] BAD_CLASS = 8'd255;
  localparam int HDR_BYTES = 2;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_TOO_LARGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NO_MEM    = 2'd2;

  // Byte size of class idx. Group g = idx/16 has step 8<<g and starts
  // where the previous group ended, at 128*(2^g - 1). Last class never fits.
  function automatic logic [31:0] class_size(input logic [7:0] idx, input int nc);
    logic [3:0]  g;
    logic [4:0]  j1;
    logic [31:0] s;
    g  = idx[7:4];
    j1 = {1'b0, idx[3:0]} + 5'd1;
    s  = (32'd128 << g) - 32'd128 + ({27'd0, j1} << ({1'b0, g} + 5'd3));
    if (32'(idx) == 32'(nc - 1)) s = 32'hFFFF_FFFF;
    return s;
  endfunction

endpackage

[design/sca_ram.sv]
module sca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

[design/size_class_block_allocator_top.sv]
// Segregated free-list allocator with size classes.
// Request channel: start/busy. A request is taken when start is high and
// busy is low; op 0 allocates req_size bytes, op 1 frees block_addr.
// Result: one per request, shown for exactly one cycle with done high
// (addr, status, size_class, heap_index). The receiver cannot stall.
// Config: cfg_valid/cfg_ready/cfg_data writes large_threshold; cfg_ready is
// always high. Write it only while the block is idle.
// Sequence, from the accepting edge to the edge that takes the result:
// too-large and free-of-zero go straight to the result. An allocation runs
// a binary class search, latches the class, reads and checks each heap it
// visits, then pops a free-list head (link bytes read from the arena) or
// makes a bump grant. A free reads the header, then the list head, then
// writes the link bytes; a bad header ends after its read. busy drops the
// cycle after the result, so the next request is taken no earlier than
// that. One request at a time; the steps follow from the shared comparator
// and one-read-port memories (free-list heads, heap remainders, arena bytes).
// Reset: synchronous rst. After reset the block walks the free-list head
// memory, one entry a cycle, all NUM_HEAPS*NUM_CLASSES (2048 by default)
// entries, clearing heads and loading heap remainders; busy is high meanwhile.
module size_class_block_allocator_top #(
  parameter int NUM_HEAPS   = sca_pkg::NUM_HEAPS_DEF,
  parameter int HEAP_BYTES  = sca_pkg::HEAP_BYTES_DEF,
  parameter int NUM_CLASSES = sca_pkg::NUM_CLASSES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          op,
  input  logic [sca_pkg::SIZE_W-1:0]    req_size,
  input  logic [sca_pkg::ADDR_W-1:0]    block_addr,
  output logic                          done,
  output logic [sca_pkg::ADDR_W-1:0]    addr,
  output logic [sca_pkg::STATUS_W-1:0]  status,
  output logic [sca_pkg::CLASS_W-1:0]   size_class,
  output logic [sca_pkg::HEAP_W-1:0]    heap_index,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [sca_pkg::THR_W-1:0]     cfg_data
);

  localparam int ARENA = NUM_HEAPS * HEAP_BYTES;
  localparam int AB    = $clog2(ARENA);
  localparam int AAW   = ((AB > sca_pkg::ADDR_W) ? AB : sca_pkg::ADDR_W) + 1;
  localparam int FLD   = NUM_HEAPS * NUM_CLASSES;
  localparam int FLW   = $clog2(FLD);
  localparam int HAW   = (NUM_HEAPS > 1) ? $clog2(NUM_HEAPS) : 1;
  localparam int HIW   = $clog2(NUM_HEAPS + 1);
  localparam int CW    = $clog2(NUM_CLASSES);
  localparam int RW    = $clog2(HEAP_BYTES + 1);
  localparam int AW    = sca_pkg::ADDR_W;

  typedef enum logic [10:0] {
    S_CLEAR  = 11'b000_0000_0001,
    S_IDLE   = 11'b000_0000_0010,
    S_SEARCH = 11'b000_0000_0100,
    S_HRD    = 11'b000_0000_1000,
    S_HCHK   = 11'b000_0001_0000,
    S_LNK    = 11'b000_0010_0000,
    S_BUMP   = 11'b000_0100_0000,
    S_FRD    = 11'b000_1000_0000,
    S_FLRD   = 11'b001_0000_0000,
    S_FWR    = 11'b010_0000_0000,
    S_DONE   = 11'b100_0000_0000
  } state_t;

  state_t state;
  logic [FLW-1:0]   clr_idx;
  logic [HIW-1:0]   cur_heap, ih;
  logic [sca_pkg::THR_W-1:0] thr;
  logic [1:0]       cnt;
  logic             req_op;
  logic [sca_pkg::SIZE_W-1:0] req;
  logic [AW-1:0]    baddr;
  logic [CW-1:0]    lo, hi, sid;
  logic [32:0]      need;
  logic [FLW-1:0]   slot;
  logic [AW-1:0]    head, old;
  logic [7:0]       lb0, lb1, hdr_sid;
  logic [AAW-1:0]   base;
  logic             ar_ok_q;
  logic [AW-1:0]    res_addr;
  logic [sca_pkg::STATUS_W-1:0] res_status;
  logic [7:0]       res_class;
  logic [sca_pkg::HEAP_W-1:0] res_heap;

  // memory ports
  logic             fl_we, hr_we, ar_we;
  logic [FLW-1:0]   fl_waddr, fl_raddr;
  logic [AW-1:0]    fl_wdata, fl_rdata;
  logic [HAW-1:0]   hr_waddr, hr_raddr;
  logic [RW-1:0]    hr_wdata, hr_rdata;
  logic [AAW-1:0]   ar_raddr, aw_addr;
  logic             ar_ok;
  logic [7:0]       aw_data, ar_rdata, abyte;

  // comb helpers
  logic [CW:0]      mid_sum;
  logic [CW-1:0]    mid;
  logic             go_up;
  logic [31:0]      hsel, csel, slot_c, base_c;
  logic             head_nz, fits, bad_hdr;

  sca_ram #(.WIDTH(AW), .DEPTH(FLD)) u_fl (
    .clk(clk), .we(fl_we), .waddr(fl_waddr), .wdata(fl_wdata),
    .raddr(fl_raddr), .rdata(fl_rdata)
  );

  sca_ram #(.WIDTH(RW), .DEPTH(NUM_HEAPS)) u_hr (
    .clk(clk), .we(hr_we), .waddr(hr_waddr), .wdata(hr_wdata),
    .raddr(hr_raddr), .rdata(hr_rdata)
  );

  sca_ram #(.WIDTH(8), .DEPTH(ARENA)) u_arena (
    .clk(clk), .we(ar_we), .waddr(aw_addr[AB-1:0]), .wdata(aw_data),
    .raddr(ar_raddr[AB-1:0]), .rdata(ar_rdata)
  );

  assign abyte = ar_ok_q ? ar_rdata : 8'd0;

  always_comb begin
    mid_sum = {1'b0, lo} + {1'b0, hi};
    mid     = mid_sum[CW:1];
    go_up   = 32'(req) > sca_pkg::class_size(8'(mid), NUM_CLASSES);

    if (state == S_FRD) begin
      hsel = 32'(abyte);
      csel = 32'(hdr_sid);
    end else begin
      hsel = 32'(ih);
      csel = 32'(sid);
    end
    slot_c = hsel * 32'(NUM_CLASSES) + csel;

    head_nz = fl_rdata != '0;
    fits    = need <= 33'(hr_rdata);
    base_c  = 32'(ih) * 32'(HEAP_BYTES) + (32'(HEAP_BYTES) - 32'(hr_rdata));
    bad_hdr = (hdr_sid == sca_pkg::BAD_CLASS) || (32'(hdr_sid) >= 32'(NUM_CLASSES)) ||
              (32'(abyte) >= 32'(NUM_HEAPS));
  end

  always_comb begin
    fl_raddr = slot_c[FLW-1:0];
    fl_we    = 1'b0;
    fl_waddr = slot;
    fl_wdata = '0;
    hr_raddr = ih[HAW-1:0];
    hr_we    = 1'b0;
    hr_waddr = ih[HAW-1:0];
    hr_wdata = hr_rdata - need[RW-1:0];
    ar_raddr = '0;
    ar_ok    = 1'b0;
    aw_addr  = '0;
    aw_data  = '0;
    ar_we    = 1'b0;
    case (state)
      S_CLEAR: begin
        fl_we    = 1'b1;
        fl_waddr = clr_idx;
        hr_we    = 32'(clr_idx) < 32'(NUM_HEAPS);
        hr_waddr = clr_idx[HAW-1:0];
        hr_wdata = RW'(HEAP_BYTES);
      end
      S_HCHK: begin
        if (!head_nz && fits) begin
          hr_we   = 1'b1;
          aw_addr = base_c[AAW-1:0];
          aw_data = 8'(ih);
          ar_we   = 1'b1;
        end
      end
      S_BUMP: begin
        aw_addr = base + AAW'(1);
        aw_data = 8'(sid);
        ar_we   = 1'b1;
      end
      S_LNK: begin
        ar_raddr = AAW'(head) + AAW'(cnt);
        ar_ok    = 1'b1;
        if (cnt == 2'd3) begin
          fl_we    = 1'b1;
          fl_wdata = {abyte[0], lb1, lb0};
        end
      end
      S_FRD: begin
        if (cnt == 2'd0) begin
          ar_raddr = AAW'(baddr) - AAW'(1);
          ar_ok    = 1'b1;
        end else begin
          ar_raddr = AAW'(baddr) - AAW'(2);
          ar_ok    = baddr >= AW'(2);
        end
      end
      S_FWR: begin
        aw_addr = AAW'(baddr) + AAW'(cnt);
        ar_we   = 1'b1;
        case (cnt)
          2'd0:    aw_data = old[7:0];
          2'd1:    aw_data = old[15:8];
          default: aw_data = {7'd0, old[16]};
        endcase
        if (cnt == 2'd2) begin
          fl_we    = 1'b1;
          fl_wdata = baddr;
        end
      end
      default: ;
    endcase
    ar_ok = ar_ok && (32'(ar_raddr) < 32'(ARENA));
    ar_we = ar_we && (32'(aw_addr) < 32'(ARENA));
  end

  always_ff @(posedge clk) begin
    ar_ok_q <= ar_ok;
    if (rst) begin
      state    <= S_CLEAR;
      clr_idx  <= '0;
      cur_heap <= '0;
      thr      <= sca_pkg::THR_RESET;
      cnt      <= '0;
    end else begin
      if (cfg_valid) thr <= cfg_data;
      case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + FLW'(1);
          if (32'(clr_idx) == 32'(FLD - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (start) begin
            req_op     <= op;
            req        <= req_size;
            baddr      <= block_addr;
            res_addr   <= '0;
            res_status <= sca_pkg::ST_OK;
            res_class  <= '0;
            res_heap   <= '0;
            cnt        <= '0;
            lo         <= '0;
            hi         <= CW'(NUM_CLASSES - 1);
            if (!op) begin
              if (req_size > 24'(thr)) begin
                res_status <= sca_pkg::ST_TOO_LARGE;
                res_class  <= sca_pkg::BAD_CLASS;
                state      <= S_DONE;
              end else begin
                state <= S_SEARCH;
              end
            end else if (block_addr == '0) begin
              state <= S_DONE;
            end else begin
              state <= S_FRD;
            end
          end
        end
        S_SEARCH: begin
          if (hi > lo) begin
            if (go_up) lo <= mid + CW'(1);
            else hi <= mid;
          end else begin
            sid       <= lo;
            res_class <= 8'(lo);
            need      <= 33'(sca_pkg::class_size(8'(lo), NUM_CLASSES)) +
                         33'(sca_pkg::HDR_BYTES);
            ih        <= cur_heap;
            state     <= S_HRD;
          end
        end
        S_HRD: begin
          slot <= slot_c[FLW-1:0];
          if (32'(ih) >= 32'(NUM_HEAPS)) begin
            res_status <= sca_pkg::ST_NO_MEM;
            state      <= S_DONE;
          end else begin
            state <= S_HCHK;
          end
        end
        S_HCHK: begin
          head <= fl_rdata;
          if (head_nz) begin
            res_addr <= fl_rdata;
            cnt      <= '0;
            state    <= S_LNK;
          end else if (fits) begin
            base     <= base_c[AAW-1:0];
            res_addr <= AW'(base_c + 32'(sca_pkg::HDR_BYTES));
            state    <= S_BUMP;
          end else begin
            // restart the walk from heap 0 once, else move on
            if (cur_heap != '0) begin
              cur_heap <= '0;
              ih       <= '0;
            end else begin
              ih <= ih + HIW'(1);
            end
            state <= S_HRD;
          end
        end
        S_LNK: begin
          cnt <= cnt + 2'd1;
          if (cnt == 2'd1) lb0 <= abyte;
          if (cnt == 2'd2) lb1 <= abyte;
          if (cnt == 2'd3) begin
            cur_heap <= ih;
            res_heap <= sca_pkg::HEAP_W'(ih);
            state    <= S_DONE;
          end
        end
        S_BUMP: begin
          cur_heap <= ih;
          res_heap <= sca_pkg::HEAP_W'(ih);
          state    <= S_DONE;
        end
        S_FRD: begin
          cnt <= cnt + 2'd1;
          if (cnt == 2'd1) hdr_sid <= abyte;
          if (cnt == 2'd2) begin
            slot      <= slot_c[FLW-1:0];
            res_class <= hdr_sid;
            res_heap  <= sca_pkg::HEAP_W'(abyte);
            if (bad_hdr) begin
              res_status <= sca_pkg::ST_TOO_LARGE;
              state      <= S_DONE;
            end else begin
              state <= S_FLRD;
            end
          end
        end
        S_FLRD: begin
          old   <= fl_rdata;
          cnt   <= '0;
          state <= S_FWR;
        end
        S_FWR: begin
          cnt <= cnt + 2'd1;
          if (cnt == 2'd2) state <= S_DONE;
        end
        S_DONE: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  assign busy       = state != S_IDLE;
  assign done       = state == S_DONE;
  assign cfg_ready  = 1'b1;
  assign addr       = res_addr;
  assign status     = res_status;
  assign size_class = res_class;
  assign heap_index = res_heap;

`ifndef SYNTH
  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("result strobe while idle");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe longer than one cycle");
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (status != 2'd3))
    else $error("undefined status code");
  a_free_addr: assert property (@(posedge clk) disable iff (rst)
    (done && req_op) |-> (addr == '0))
    else $error("free returned an address");
`endif

endmodule
